// ===== rtl/pdpb_pkg.sv =====
// Shared types, constants and fixed-point helpers of the pion decay photon boost.
// Used by pdpb_cordic and pion_decay_photon_boost_top; depends on nothing else.
`default_nettype none
package pdpb_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS = 20;
  localparam int EN_BITS   = FRAC_BITS + 4;
  localparam int MO_BITS   = FRAC_BITS + 5;
  localparam int AW        = EN_BITS + 4;

  localparam logic [EN_BITS-1:0] REST_MASS_RESET = EN_BITS'(141526);

  // Register indexes on the configuration port
  localparam logic [1:0] REG_REST_MASS  = 2'd0;
  localparam logic [1:0] REG_POLAR_MIN  = 2'd1;
  localparam logic [1:0] REG_POLAR_MAX  = 2'd2;

  localparam logic signed [AW-1:0] EN_TOP = AW'(2**EN_BITS - 1);
  localparam logic signed [AW-1:0] MO_TOP = AW'(2**(MO_BITS-1) - 1);
  localparam logic signed [AW-1:0] MO_BOT = -AW'(2**(MO_BITS-1));

  localparam logic signed [63:0] RND30 = 64'sd536870912;
  localparam logic signed [63:0] ONE30 = 64'sd1073741824;

  // Arctangent steps on a 32-bit turn
  localparam logic [31:0] ARC_TAB [0:29] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  // Zero-extend an unsigned energy-range value to the working width
  function automatic logic signed [AW-1:0] to_aw(input logic [EN_BITS:0] v);
    return $signed({{(AW-EN_BITS-1){1'b0}}, v});
  endfunction

  // a * t / 2^30, magnitude rounded half up, sign applied after
  function automatic logic signed [AW-1:0] mulq(input logic signed [AW-1:0] a,
                                                input logic signed [31:0] t);
    logic          neg;
    logic [AW-1:0] ma;
    logic [31:0]   mt;
    logic [AW+31:0] pr;
    logic [AW-1:0] r;
    neg = a[AW-1] ^ t[31];
    ma  = a[AW-1] ? AW'(-a) : AW'(a);
    mt  = t[31] ? 32'(-t) : 32'(t);
    pr  = (AW+32)'(ma) * (AW+32)'(mt) + (AW+32)'(536870912);
    r   = pr[AW+29:30];
    return neg ? -$signed(r) : $signed(r);
  endfunction

  // Q30 by Q30 product, rounded then floor-shifted
  function automatic logic signed [31:0] q30mul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [63:0] pr;
    pr = 64'(a) * 64'(b) + RND30;
    return 32'(pr >>> 30);
  endfunction

  // Saturate to the unsigned energy range
  function automatic logic [EN_BITS-1:0] sat_en(input logic signed [AW-1:0] v);
    logic [EN_BITS-1:0] r;
    if (v < 0) r = '0;
    else if (v > EN_TOP) r = EN_TOP[EN_BITS-1:0];
    else r = v[EN_BITS-1:0];
    return r;
  endfunction

  // Saturate to the signed momentum range
  function automatic logic signed [MO_BITS-1:0] sat_mo(input logic signed [AW-1:0] v);
    logic signed [MO_BITS-1:0] r;
    if (v < MO_BOT) r = MO_BOT[MO_BITS-1:0];
    else if (v > MO_TOP) r = MO_TOP[MO_BITS-1:0];
    else r = v[MO_BITS-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pdpb_cordic.sv =====
// Pipelined rotation CORDIC: angle code in, Q30 cosine and sine out.
// Depends on pdpb_pkg for the arctangent table.
`default_nettype none
module pdpb_cordic #(
  parameter int ANGLE_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic [ANGLE_BITS-1:0] code,
  output logic signed [31:0]         cos_q,
  output logic signed [31:0]         sin_q
);

  localparam logic signed [33:0] QUARTER = 34'sd1073741824;
  localparam logic signed [33:0] HALF    = 34'sd2147483648;
  localparam logic signed [33:0] GAIN    = 34'sd652032874;

  logic signed [33:0] xs [0:30];
  logic signed [33:0] ys [0:30];
  logic signed [33:0] zs [0:30];
  logic               fs [0:30];

  logic [31:0]        turn;
  logic signed [33:0] z_in, z_pre;
  logic               flip_pre;
  logic signed [33:0] x_fin, y_fin;

  // Fold the angle into the right half plane
  always_comb begin
    turn     = {code, {(32-ANGLE_BITS){1'b0}}};
    z_in     = 34'($signed(turn));
    z_pre    = z_in;
    flip_pre = 1'b0;
    if (z_in > QUARTER) begin
      z_pre    = z_in - HALF;
      flip_pre = 1'b1;
    end else if (z_in < -QUARTER) begin
      z_pre    = z_in + HALF;
      flip_pre = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= GAIN;
      ys[0] <= '0;
      zs[0] <= z_pre;
      fs[0] <= flip_pre;
    end
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < 30; i++) begin : g_iter
    logic signed [33:0] dx, dy, arc;
    assign dx  = xs[i] >>> i;
    assign dy  = ys[i] >>> i;
    assign arc = $signed({2'b00, pdpb_pkg::ARC_TAB[i]});
    always_ff @(posedge clk) begin
      if (en) begin
        fs[i+1] <= fs[i];
        if (zs[i] >= 0) begin
          xs[i+1] <= xs[i] - dy;
          ys[i+1] <= ys[i] + dx;
          zs[i+1] <= zs[i] - arc;
        end else begin
          xs[i+1] <= xs[i] + dy;
          ys[i+1] <= ys[i] - dx;
          zs[i+1] <= zs[i] + arc;
        end
      end
    end
  end

  // Undo the fold and clamp to the unit range
  always_comb begin
    x_fin = fs[30] ? -xs[30] : xs[30];
    y_fin = fs[30] ? -ys[30] : ys[30];
    if (x_fin > QUARTER) x_fin = QUARTER;
    else if (x_fin < -QUARTER) x_fin = -QUARTER;
    if (y_fin > QUARTER) y_fin = QUARTER;
    else if (y_fin < -QUARTER) y_fin = -QUARTER;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= 32'(x_fin);
      sin_q <= 32'(y_fin);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pion_decay_photon_boost_top.sv =====
// Top level of the pion decay photon boost: APB registers, CORDIC lanes,
// square-root pipeline and boost arithmetic. Depends on pdpb_pkg and pdpb_cordic.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------
//  in       | in_valid / in_stall     | meson_energy, meson/decay polar, azimuth
//  out      | out_valid / out_stall   | first_*, second_*, accepted
//  config   | psel/penable/pwrite     | paddr, pwdata, prdata (pready tied high)
//
// One transaction enters per cycle while in_stall is low.
// The depth is set by the 32-stage CORDIC lanes (fold, 30 steps, clamp) plus nine
// boost stages after them.
// The whole pipeline holds while a finished result is stalled; nothing is lost.
// Reset clears the valid bits and loads the register defaults.
// A limit write takes effect once the free-running limit CORDICs have settled.
`default_nettype none
module pion_decay_photon_boost_top #(
  parameter int ANGLE_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [pdpb_pkg::EN_BITS-1:0]        meson_energy,
  input  wire logic [ANGLE_BITS-1:0]               meson_polar,
  input  wire logic [ANGLE_BITS-1:0]               meson_azimuth,
  input  wire logic [ANGLE_BITS-1:0]               decay_polar,
  input  wire logic [ANGLE_BITS-1:0]               decay_azimuth,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [pdpb_pkg::MO_BITS-1:0]      first_px,
  output logic signed [pdpb_pkg::MO_BITS-1:0]      first_py,
  output logic signed [pdpb_pkg::MO_BITS-1:0]      first_pz,
  output logic [pdpb_pkg::EN_BITS-1:0]             first_energy,
  output logic signed [pdpb_pkg::MO_BITS-1:0]      second_px,
  output logic signed [pdpb_pkg::MO_BITS-1:0]      second_py,
  output logic signed [pdpb_pkg::MO_BITS-1:0]      second_pz,
  output logic [pdpb_pkg::EN_BITS-1:0]             second_energy,
  output logic                                     accepted,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [3:0]                          paddr,
  input  wire logic [31:0]                         pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);

  localparam int EN = pdpb_pkg::EN_BITS;
  localparam int AW = pdpb_pkg::AW;
  localparam int RB = EN + 1;
  localparam int LAST = 40;
  localparam logic [ANGLE_BITS-1:0] HALF_CODE = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

  // Configuration registers
  logic [EN-1:0]         rest_mass;
  logic [ANGLE_BITS-1:0] polar_min, polar_max;
  logic                  wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      rest_mass <= pdpb_pkg::REST_MASS_RESET;
      polar_min <= '0;
      polar_max <= HALF_CODE;
    end else if (wr) begin
      case (paddr[3:2])
        pdpb_pkg::REG_REST_MASS: rest_mass <= pwdata[EN-1:0];
        pdpb_pkg::REG_POLAR_MIN: polar_min <= pwdata[ANGLE_BITS-1:0];
        pdpb_pkg::REG_POLAR_MAX: polar_max <= pwdata[ANGLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      pdpb_pkg::REG_REST_MASS: prdata = 32'(rest_mass);
      pdpb_pkg::REG_POLAR_MIN: prdata = 32'(polar_min);
      pdpb_pkg::REG_POLAR_MAX: prdata = 32'(polar_max);
      default:                 prdata = '0;
    endcase
  end

  // Angle window: saturate limits to pi and run a free CORDIC on each
  logic [ANGLE_BITS-1:0] lim_min, lim_max;
  logic                  lim_ok;
  logic signed [31:0]    cos_min, cos_max;

  assign lim_min = (polar_min > HALF_CODE) ? HALF_CODE : polar_min;
  assign lim_max = (polar_max > HALF_CODE) ? HALF_CODE : polar_max;
  assign lim_ok  = lim_min <= lim_max;

  pdpb_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_min (
    .clk(clk), .en(1'b1), .code(lim_min), .cos_q(cos_min), .sin_q()
  );
  pdpb_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_max (
    .clk(clk), .en(1'b1), .code(lim_max), .cos_q(cos_max), .sin_q()
  );

  // Pipeline advance and valid bits
  logic            adv;
  logic [LAST:0]   vld;

  assign adv       = !(vld[LAST] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST-1:0], in_valid};
    end
  end

  // Direction CORDIC lanes, stages 0 to 31
  logic signed [31:0] cmt, smt, cmp, smp, cdt, sdt, cdp, sdp;

  pdpb_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_mt (
    .clk(clk), .en(adv), .code(meson_polar), .cos_q(cmt), .sin_q(smt)
  );
  pdpb_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_mp (
    .clk(clk), .en(adv), .code(meson_azimuth), .cos_q(cmp), .sin_q(smp)
  );
  pdpb_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_dt (
    .clk(clk), .en(adv), .code(decay_polar), .cos_q(cdt), .sin_q(sdt)
  );
  pdpb_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_dp (
    .clk(clk), .en(adv), .code(decay_azimuth), .cos_q(cdp), .sin_q(sdp)
  );

  // Momentum path: excess, product, then one root bit per stage
  logic [EN-1:0]     e_d [0:35];
  logic [EN-1:0]     d_d [1:34];
  logic [RB-1:0]     sum1;
  logic [2*RB-1:0]   sq_n    [0:25];
  logic [27:0]       sq_rem  [0:25];
  logic [RB-1:0]     sq_root [0:25];
  logic [RB-1:0]     p_d [28:35];

  always_ff @(posedge clk) begin
    if (adv) begin
      e_d[0] <= meson_energy;
      for (int k = 1; k < 36; k++) e_d[k] <= e_d[k-1];
      d_d[1] <= (e_d[0] >= rest_mass) ? (e_d[0] - rest_mass) : '0;
      sum1   <= RB'(e_d[0]) + RB'(rest_mass);
      for (int k = 2; k < 35; k++) d_d[k] <= d_d[k-1];
      sq_n[0]    <= (2*RB)'(RB'(d_d[1]) * sum1);
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      p_d[28] <= sq_root[25];
      for (int k = 29; k < 36; k++) p_d[k] <= p_d[k-1];
    end
  end

  for (genvar j = 0; j < 25; j++) begin : g_sqrt
    logic [27:0] rem_w, trial;
    assign rem_w = {sq_rem[j][25:0], sq_n[j][2*RB-1:2*RB-2]};
    assign trial = 28'({sq_root[j], 2'b01});
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_n[j+1] <= sq_n[j] << 2;
        if (rem_w >= trial) begin
          sq_rem[j+1]  <= rem_w - trial;
          sq_root[j+1] <= {sq_root[j][RB-2:0], 1'b1};
        end else begin
          sq_rem[j+1]  <= rem_w;
          sq_root[j+1] <= {sq_root[j][RB-2:0], 1'b0};
        end
      end
    end
  end

  // Boost stages 32 to 40
  logic signed [31:0] n32 [3], u32 [3];
  logic signed [63:0] dot33 [3];
  logic signed [31:0] n33 [3], n34 [3], n35 [3], n36 [3];
  logic signed [AW-1:0] mu33 [3], mu34 [3], mu35 [3], mu36 [3], mu37 [3];
  logic signed [31:0] cang34;
  logic signed [AW-1:0] pc35, dc35, s1_36, s2_36;
  logic [EN-1:0]      en1_36, en2_36, en1_37, en2_37, en1_38, en2_38, en1_39, en2_39;
  logic signed [AW-1:0] ps1_37 [3], ps2_37 [3];
  logic signed [pdpb_pkg::MO_BITS-1:0] v1_38 [3], v2_38 [3], v1_39 [3], v2_39 [3];
  logic signed [AW-1:0] t1min, t1max, t2min, t2max;

  logic signed [63:0] dot_acc, dot_r;
  logic signed [31:0] cang_next;

  // Round and clamp the direction cosine
  always_comb begin
    dot_acc = dot33[0] + dot33[1] + dot33[2] + pdpb_pkg::RND30;
    dot_r   = dot_acc >>> 30;
    if (dot_r > pdpb_pkg::ONE30) dot_r = pdpb_pkg::ONE30;
    else if (dot_r < -pdpb_pkg::ONE30) dot_r = -pdpb_pkg::ONE30;
    cang_next = 32'(dot_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 32: unit vectors
      n32[0] <= pdpb_pkg::q30mul(smt, cmp);
      n32[1] <= pdpb_pkg::q30mul(smt, smp);
      n32[2] <= cmt;
      u32[0] <= pdpb_pkg::q30mul(sdt, cdp);
      u32[1] <= pdpb_pkg::q30mul(sdt, sdp);
      u32[2] <= cdt;
      // stage 33: dot products and rest-frame momenta
      for (int k = 0; k < 3; k++) begin
        dot33[k] <= 64'(n32[k]) * 64'(u32[k]);
        mu33[k]  <= pdpb_pkg::mulq(pdpb_pkg::to_aw({1'b0, rest_mass}), u32[k]);
        n33[k]   <= n32[k];
      end
      // stage 34: cosine of the opening angle
      cang34 <= cang_next;
      for (int k = 0; k < 3; k++) begin
        mu34[k] <= mu33[k];
        n34[k]  <= n33[k];
      end
      // stage 35: projections of momentum and excess
      pc35 <= pdpb_pkg::mulq(pdpb_pkg::to_aw(p_d[34]), cang34);
      dc35 <= pdpb_pkg::mulq(pdpb_pkg::to_aw({1'b0, d_d[34]}), cang34);
      for (int k = 0; k < 3; k++) begin
        mu35[k] <= mu34[k];
        n35[k]  <= n34[k];
      end
      // stage 36: lab energies and boost scales
      en1_36 <= pdpb_pkg::sat_en((pdpb_pkg::to_aw({1'b0, e_d[35]}) + pc35) >>> 1);
      en2_36 <= pdpb_pkg::sat_en((pdpb_pkg::to_aw({1'b0, e_d[35]}) - pc35) >>> 1);
      s1_36  <= pdpb_pkg::to_aw(p_d[35]) + dc35;
      s2_36  <= pdpb_pkg::to_aw(p_d[35]) - dc35;
      for (int k = 0; k < 3; k++) begin
        mu36[k] <= mu35[k];
        n36[k]  <= n35[k];
      end
      // stage 37: boosted components along the meson direction
      for (int k = 0; k < 3; k++) begin
        ps1_37[k] <= pdpb_pkg::mulq(s1_36, n36[k]);
        ps2_37[k] <= pdpb_pkg::mulq(s2_36, n36[k]);
        mu37[k]   <= mu36[k];
      end
      en1_37 <= en1_36;
      en2_37 <= en2_36;
      // stage 38: lab momenta
      for (int k = 0; k < 3; k++) begin
        v1_38[k] <= pdpb_pkg::sat_mo((mu37[k] + ps1_37[k]) >>> 1);
        v2_38[k] <= pdpb_pkg::sat_mo((ps2_37[k] - mu37[k]) >>> 1);
      end
      en1_38 <= en1_37;
      en2_38 <= en2_37;
      // stage 39: window thresholds
      t1min <= pdpb_pkg::mulq(pdpb_pkg::to_aw({1'b0, en1_38}), cos_min);
      t1max <= pdpb_pkg::mulq(pdpb_pkg::to_aw({1'b0, en1_38}), cos_max);
      t2min <= pdpb_pkg::mulq(pdpb_pkg::to_aw({1'b0, en2_38}), cos_min);
      t2max <= pdpb_pkg::mulq(pdpb_pkg::to_aw({1'b0, en2_38}), cos_max);
      for (int k = 0; k < 3; k++) begin
        v1_39[k] <= v1_38[k];
        v2_39[k] <= v2_38[k];
      end
      en1_39 <= en1_38;
      en2_39 <= en2_38;
      // stage 40: output register and accept decision
      first_px      <= v1_39[0];
      first_py      <= v1_39[1];
      first_pz      <= v1_39[2];
      first_energy  <= en1_39;
      second_px     <= v2_39[0];
      second_py     <= v2_39[1];
      second_pz     <= v2_39[2];
      second_energy <= en2_39;
      accepted <= lim_ok
               && (en1_39 != '0) && (AW'(v1_39[2]) <= t1min) && (AW'(v1_39[2]) >= t1max)
               && (en2_39 != '0) && (AW'(v2_39[2]) <= t2min) && (AW'(v2_39[2]) >= t2max);
    end
  end

endmodule
`default_nettype wire
